// ===== rtl/smp_pkg.sv =====
// ----------------------------------------------------------------------------
// smp_pkg
// Types and constants shared by the STUN message parser and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package smp_pkg;

  localparam int unsigned HDR_BYTES  = 20;
  localparam int unsigned TXID_BYTES = 12;
  localparam int unsigned ALIGN      = 4;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [4:0] HC_LEN        = 5'd2;
  localparam logic [4:0] HC_MAGIC      = 5'd4;
  localparam logic [4:0] HC_TXID       = 5'(HDR_BYTES - TXID_BYTES);
  localparam logic [4:0] HC_MAGIC_LAST = 5'(HDR_BYTES - TXID_BYTES - 1);
  localparam logic [4:0] HC_TXLOW      = 5'(HDR_BYTES - TXID_BYTES + 4);
  localparam logic [4:0] HC_DONE       = 5'(HDR_BYTES);

  localparam logic [31:0] MAGIC_RESET     = 32'h2112A442;
  localparam logic [15:0] USER_TYPE_RESET = 16'd6;
  localparam logic [15:0] PASS_TYPE_RESET = 16'd7;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'b0001,
    PH_ATTR_HDR = 4'b0010,
    PH_ATTR_VAL = 4'b0100,
    PH_SKIP     = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_USERNAME = 2'd0,
    KIND_PASSWORD = 2'd1,
    KIND_SUMMARY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_BAD_MAGIC = 2'd2,
    ST_OVERRUN   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_MAGIC     = 2'd0,
    CFG_USER_TYPE = 2'd1,
    CFG_PASS_TYPE = 2'd2
  } cfg_index_e;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   value_byte;
    logic [15:0]  value_index;
    logic [15:0]  msg_type;
    logic [15:0]  msg_len;
    logic [31:0]  tx_high;
    logic [63:0]  tx_low;
    status_e      status;
    logic         last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/stun_message_parser_top.sv =====
// ----------------------------------------------------------------------------
// stun_message_parser_top
// Parses a STUN header and attribute list one byte per cycle unless stalled,
// streams username and password value bytes and ends each packet with a summary.
// ----------------------------------------------------------------------------
// Each result is written into the registered result queue when its byte is taken.
// Throughput: one byte per cycle unless stalled; the final byte of a packet that is
//   also a username or password byte yields two results, queued together.
// Input stalls while the four-entry result queue has fewer than two free slots.
// Reset: registers go to their defaults, parser to header phase, queue empty.
`default_nettype none

module stun_message_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  packet_byte_i,
  input  wire logic        end_of_packet_i,

  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [1:0]  result_kind_o,
  output      logic [7:0]  value_byte_o,
  output      logic [15:0] value_index_o,
  output      logic [15:0] message_type_o,
  output      logic [15:0] message_length_o,
  output      logic [31:0] transaction_high_o,
  output      logic [63:0] transaction_low_o,
  output      logic [1:0]  parse_status_o,
  output      logic        last_of_run_o,

  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned PTR_W = smp_pkg::PTR_W;
  localparam int unsigned CNT_W = smp_pkg::CNT_W;

  // configuration
  logic [31:0] magic_cookie_q;
  logic [15:0] user_type_q;
  logic [15:0] pass_type_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_cookie_q <= smp_pkg::MAGIC_RESET;
      user_type_q    <= smp_pkg::USER_TYPE_RESET;
      pass_type_q    <= smp_pkg::PASS_TYPE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        smp_pkg::CFG_MAGIC:     magic_cookie_q <= cfg_data_i;
        smp_pkg::CFG_USER_TYPE: user_type_q    <= cfg_data_i[15:0];
        smp_pkg::CFG_PASS_TYPE: pass_type_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // parser state
  smp_pkg::phase_e phase_q, phase_d;
  logic [4:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] magic_q, magic_d;
  logic [15:0] type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [31:0] txh_q, txh_d;
  logic [63:0] txl_q, txl_d;
  logic [1:0]  ahdr_cnt_q, ahdr_cnt_d;
  logic [15:0] atype_q, atype_d;
  logic [15:0] alen_q, alen_d;
  logic [16:0] abyte_cnt_q, abyte_cnt_d;
  logic [16:0] apad_len_q, apad_len_d;

  logic            accept;
  logic            val_hit;
  smp_pkg::kind_e  val_kind;
  smp_pkg::status_e sum_status;
  smp_pkg::result_t val_res, sum_res, res_a, res_b;
  logic            push_a, push_b;
  logic [16:0]     abyte_inc;
  logic [1:0]      pad;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    magic_d     = magic_q;
    type_d      = type_q;
    len_d       = len_q;
    txh_d       = txh_q;
    txl_d       = txl_q;
    ahdr_cnt_d  = ahdr_cnt_q;
    atype_d     = atype_q;
    alen_d      = alen_q;
    abyte_cnt_d = abyte_cnt_q;
    apad_len_d  = apad_len_q;
    val_hit     = 1'b0;
    val_kind    = smp_pkg::KIND_USERNAME;
    abyte_inc   = abyte_cnt_q + 17'd1;
    pad         = 2'd0;

    case (phase_q)
      smp_pkg::PH_HEADER: begin
        if (hdr_cnt_q < smp_pkg::HC_LEN) begin
          type_d = {type_q[7:0], packet_byte_i};
        end else if (hdr_cnt_q < smp_pkg::HC_MAGIC) begin
          len_d = {len_q[7:0], packet_byte_i};
        end else if (hdr_cnt_q < smp_pkg::HC_TXID) begin
          magic_d = {magic_q[23:0], packet_byte_i};
          if (hdr_cnt_q == smp_pkg::HC_MAGIC_LAST && magic_d != magic_cookie_q) begin
            phase_d = smp_pkg::PH_SKIP;
          end
        end else if (hdr_cnt_q < smp_pkg::HC_TXLOW) begin
          txh_d = {txh_q[23:0], packet_byte_i};
        end else begin
          txl_d = {txl_q[55:0], packet_byte_i};
        end
        hdr_cnt_d = hdr_cnt_q + 5'd1;
        if (phase_d == smp_pkg::PH_HEADER && hdr_cnt_d >= smp_pkg::HC_DONE) begin
          phase_d    = smp_pkg::PH_ATTR_HDR;
          ahdr_cnt_d = 2'd0;
        end
      end
      smp_pkg::PH_ATTR_HDR: begin
        if (!ahdr_cnt_q[1]) begin
          atype_d = {atype_q[7:0], packet_byte_i};
        end else begin
          alen_d = {alen_q[7:0], packet_byte_i};
        end
        if (ahdr_cnt_q == 2'd3) begin
          ahdr_cnt_d  = 2'd0;
          abyte_cnt_d = 17'd0;
          pad         = 2'd0 - alen_d[1:0];
          apad_len_d  = {1'b0, alen_d} + {15'd0, pad};
          if (apad_len_d != 17'd0) begin
            phase_d = smp_pkg::PH_ATTR_VAL;
          end
        end else begin
          ahdr_cnt_d = ahdr_cnt_q + 2'd1;
        end
      end
      smp_pkg::PH_ATTR_VAL: begin
        if (abyte_cnt_q < {1'b0, alen_q}) begin
          if (atype_q == user_type_q) begin
            val_hit  = 1'b1;
            val_kind = smp_pkg::KIND_USERNAME;
          end else if (atype_q == pass_type_q) begin
            val_hit  = 1'b1;
            val_kind = smp_pkg::KIND_PASSWORD;
          end
        end
        if (abyte_inc >= apad_len_q) begin
          phase_d     = smp_pkg::PH_ATTR_HDR;
          ahdr_cnt_d  = 2'd0;
          abyte_cnt_d = 17'd0;
        end else begin
          abyte_cnt_d = abyte_inc;
        end
      end
      default: ;
    endcase

    case (phase_d)
      smp_pkg::PH_HEADER:   sum_status = smp_pkg::ST_SHORT;
      smp_pkg::PH_SKIP:     sum_status = smp_pkg::ST_BAD_MAGIC;
      smp_pkg::PH_ATTR_VAL: sum_status = smp_pkg::ST_OVERRUN;
      default:              sum_status = smp_pkg::ST_OK;
    endcase

    val_res             = '0;
    val_res.kind        = val_kind;
    val_res.value_byte  = packet_byte_i;
    val_res.value_index = abyte_cnt_q[15:0];
    val_res.status      = smp_pkg::ST_OK;
    val_res.last        = !end_of_packet_i;

    sum_res             = '0;
    sum_res.kind        = smp_pkg::KIND_SUMMARY;
    sum_res.msg_type    = type_d;
    sum_res.msg_len     = len_d;
    sum_res.tx_high     = txh_d;
    sum_res.tx_low      = txl_d;
    sum_res.status      = sum_status;
    sum_res.last        = 1'b1;

    res_a  = val_hit ? val_res : sum_res;
    res_b  = sum_res;
    push_a = accept && (val_hit || end_of_packet_i);
    push_b = accept && val_hit && end_of_packet_i;

    // clear per-packet state after the final byte
    if (end_of_packet_i) begin
      phase_d     = smp_pkg::PH_HEADER;
      hdr_cnt_d   = 5'd0;
      magic_d     = '0;
      type_d      = '0;
      len_d       = '0;
      txh_d       = '0;
      txl_d       = '0;
      ahdr_cnt_d  = 2'd0;
      atype_d     = '0;
      alen_d      = '0;
      abyte_cnt_d = '0;
      apad_len_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= smp_pkg::PH_HEADER;
      hdr_cnt_q   <= '0;
      magic_q     <= '0;
      type_q      <= '0;
      len_q       <= '0;
      txh_q       <= '0;
      txl_q       <= '0;
      ahdr_cnt_q  <= '0;
      atype_q     <= '0;
      alen_q      <= '0;
      abyte_cnt_q <= '0;
      apad_len_q  <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      magic_q     <= magic_d;
      type_q      <= type_d;
      len_q       <= len_d;
      txh_q       <= txh_d;
      txl_q       <= txl_d;
      ahdr_cnt_q  <= ahdr_cnt_d;
      atype_q     <= atype_d;
      alen_q      <= alen_d;
      abyte_cnt_q <= abyte_cnt_d;
      apad_len_q  <= apad_len_d;
    end
  end

  // result queue
  smp_pkg::result_t fifo_q [smp_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_b;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;
  smp_pkg::result_t head;

  assign wr_ptr_b = wr_ptr_q + PTR_W'(1);
  assign pop      = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_a) + PTR_W'(push_b);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < smp_pkg::FIFO_DEPTH; i++) begin
      if (push_a && wr_ptr_q == PTR_W'(i)) begin
        fifo_q[i] <= res_a;
      end else if (push_b && wr_ptr_b == PTR_W'(i)) begin
        fifo_q[i] <= res_b;
      end
    end
  end

  assign in_stall_o = count_q > CNT_W'(smp_pkg::FIFO_DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign head        = fifo_q[rd_ptr_q];

  assign result_kind_o      = head.kind;
  assign value_byte_o       = head.value_byte;
  assign value_index_o      = head.value_index;
  assign message_type_o     = head.msg_type;
  assign message_length_o   = head.msg_len;
  assign transaction_high_o = head.tx_high;
  assign transaction_low_o  = head.tx_low;
  assign parse_status_o     = head.status;
  assign last_of_run_o      = head.last;

endmodule

`default_nettype wire

// ===== rtl/smp_checker.sv =====
// ----------------------------------------------------------------------------
// smp_checker
// Port-level checks for the STUN message parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  result_kind_o,
  input wire logic [7:0]  value_byte_o,
  input wire logic [15:0] value_index_o,
  input wire logic [15:0] message_type_o,
  input wire logic [15:0] message_length_o,
  input wire logic [31:0] transaction_high_o,
  input wire logic [63:0] transaction_low_o,
  input wire logic [1:0]  parse_status_o,
  input wire logic        last_of_run_o
);

  logic is_summary;
  assign is_summary = out_valid_o && result_kind_o == smp_pkg::KIND_SUMMARY;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(value_byte_o) && $stable(value_index_o) && $stable(last_of_run_o))
    else $error("stalled request changed");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_summary |-> last_of_run_o)
    else $error("summary not last of run");

  a_value_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_summary |-> message_type_o == '0 && message_length_o == '0
      && transaction_high_o == '0 && transaction_low_o == '0
      && parse_status_o == smp_pkg::ST_OK)
    else $error("value request carries header fields");

  a_bad_magic_txid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_summary && parse_status_o == smp_pkg::ST_BAD_MAGIC
      |-> transaction_high_o == '0 && transaction_low_o == '0)
    else $error("bad magic summary with transaction id");

  a_value_not_last_then_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_summary && !last_of_run_o && !out_stall_i
      |=> is_summary)
    else $error("value request not followed by summary");

endmodule

bind stun_message_parser_top smp_checker u_smp_checker (.*);

`default_nettype wire

// ===== bench/tb_stun_message_parser_top.sv =====
// ----------------------------------------------------------------------------
// tb_stun_message_parser_top
// Drives STUN packets into the parser one byte per request and compares each
// streamed username, password and summary result, field by field, against a
// behavioral parser kept in step with the accepted bytes. The packets are
// mostly well formed, with random endings, random idles on both sides and
// several settings of the magic value and attribute type registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stun_message_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    END_CLEAN,
    END_TRAILING,
    END_OVERRUN,
    END_SHORT_HEADER,
    END_BAD_MAGIC,
    END_NOISE
  } packet_end_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  packet_byte_i = 8'h00;
  logic        end_of_packet_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  value_byte_o;
  logic [15:0] value_index_o;
  logic [15:0] message_type_o;
  logic [15:0] message_length_o;
  logic [31:0] transaction_high_o;
  logic [63:0] transaction_low_o;
  logic [1:0]  parse_status_o;
  logic        last_of_run_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [31:0] cfg_data_i = 32'h0;

  logic [31:0] cookie_cfg    = smp_pkg::MAGIC_RESET;
  logic [15:0] user_type_cfg = smp_pkg::USER_TYPE_RESET;
  logic [15:0] pass_type_cfg = smp_pkg::PASS_TYPE_RESET;

  logic [4:0]  hdr_count      = '0;
  logic [31:0] magic_acc      = '0;
  logic [15:0] msg_type_acc   = '0;
  logic [15:0] msg_len_acc    = '0;
  logic [31:0] tx_high_acc    = '0;
  logic [63:0] tx_low_acc     = '0;
  logic [1:0]  attr_hdr_count = '0;
  logic [15:0] attr_type_acc  = '0;
  logic [15:0] attr_len_acc   = '0;
  logic [16:0] attr_pos       = '0;
  smp_pkg::phase_e parse_phase = smp_pkg::PH_HEADER;

  smp_pkg::result_t due_results[$];
  smp_pkg::result_t oldest_result;
  int      mismatch_count = 0;
  int      bytes_sent = 0;
  bit      quiet = 1'b0;

  stun_message_parser_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .packet_byte_i      (packet_byte_i),
    .end_of_packet_i    (end_of_packet_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .value_byte_o       (value_byte_o),
    .value_index_o      (value_index_o),
    .message_type_o     (message_type_o),
    .message_length_o   (message_length_o),
    .transaction_high_o (transaction_high_o),
    .transaction_low_o  (transaction_low_o),
    .parse_status_o     (parse_status_o),
    .last_of_run_o      (last_of_run_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int aligned_len(input logic [15:0] len);
    return int'(len) + int'((smp_pkg::ALIGN - (len % smp_pkg::ALIGN)) % smp_pkg::ALIGN);
  endfunction

  function automatic void clear_parser();
    hdr_count      = '0;
    magic_acc      = '0;
    msg_type_acc   = '0;
    msg_len_acc    = '0;
    tx_high_acc    = '0;
    tx_low_acc     = '0;
    attr_hdr_count = '0;
    attr_type_acc  = '0;
    attr_len_acc   = '0;
    attr_pos       = '0;
    parse_phase    = smp_pkg::PH_HEADER;
  endfunction

  function automatic smp_pkg::result_t make_result(input smp_pkg::kind_e k,
                                                   input logic [7:0] vb,
                                                   input logic [15:0] vi,
                                                   input smp_pkg::status_e st);
    smp_pkg::result_t r;
    r = '0;
    r.kind        = k;
    r.value_byte  = vb;
    r.value_index = vi;
    r.status      = st;
    if (k == smp_pkg::KIND_SUMMARY) begin
      r.msg_type = msg_type_acc;
      r.msg_len  = msg_len_acc;
      r.tx_high  = tx_high_acc;
      r.tx_low   = tx_low_acc;
    end
    return r;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input bit eop);
    smp_pkg::result_t run[$];
    smp_pkg::status_e st;
    case (parse_phase)
      smp_pkg::PH_HEADER: begin
        if (hdr_count < smp_pkg::HC_LEN) begin
          msg_type_acc = {msg_type_acc[7:0], b};
        end else if (hdr_count < smp_pkg::HC_MAGIC) begin
          msg_len_acc = {msg_len_acc[7:0], b};
        end else if (hdr_count < smp_pkg::HC_TXID) begin
          magic_acc = {magic_acc[23:0], b};
          if (hdr_count == smp_pkg::HC_MAGIC_LAST && magic_acc != cookie_cfg) begin
            parse_phase = smp_pkg::PH_SKIP;
          end
        end else if (hdr_count < smp_pkg::HC_TXLOW) begin
          tx_high_acc = {tx_high_acc[23:0], b};
        end else begin
          tx_low_acc = {tx_low_acc[55:0], b};
        end
        hdr_count = hdr_count + 5'd1;
        if (parse_phase == smp_pkg::PH_HEADER && hdr_count >= smp_pkg::HC_DONE) begin
          parse_phase    = smp_pkg::PH_ATTR_HDR;
          attr_hdr_count = '0;
        end
      end
      smp_pkg::PH_ATTR_HDR: begin
        if (attr_hdr_count < 2'd2) begin
          attr_type_acc = {attr_type_acc[7:0], b};
        end else begin
          attr_len_acc = {attr_len_acc[7:0], b};
        end
        if (attr_hdr_count == 2'd3) begin
          attr_hdr_count = '0;
          attr_pos       = '0;
          if (aligned_len(attr_len_acc) != 0) begin
            parse_phase = smp_pkg::PH_ATTR_VAL;
          end
        end else begin
          attr_hdr_count = attr_hdr_count + 2'd1;
        end
      end
      smp_pkg::PH_ATTR_VAL: begin
        if (attr_pos < attr_len_acc) begin
          if (attr_type_acc == user_type_cfg) begin
            run.push_back(make_result(smp_pkg::KIND_USERNAME, b, attr_pos[15:0],
                                      smp_pkg::ST_OK));
          end else if (attr_type_acc == pass_type_cfg) begin
            run.push_back(make_result(smp_pkg::KIND_PASSWORD, b, attr_pos[15:0],
                                      smp_pkg::ST_OK));
          end
        end
        attr_pos = attr_pos + 17'd1;
        if (attr_pos >= aligned_len(attr_len_acc)) begin
          parse_phase    = smp_pkg::PH_ATTR_HDR;
          attr_hdr_count = '0;
          attr_pos       = '0;
        end
      end
      default: begin
      end
    endcase
    if (eop) begin
      case (parse_phase)
        smp_pkg::PH_HEADER:   st = smp_pkg::ST_SHORT;
        smp_pkg::PH_SKIP:     st = smp_pkg::ST_BAD_MAGIC;
        smp_pkg::PH_ATTR_VAL: st = smp_pkg::ST_OVERRUN;
        default:              st = smp_pkg::ST_OK;
      endcase
      run.push_back(make_result(smp_pkg::KIND_SUMMARY, 8'h00, 16'h0000, st));
      clear_parser();
    end
    if (run.size() > 0) begin
      run[run.size() - 1].last = 1'b1;
    end
    foreach (run[i]) begin
      due_results.push_back(run[i]);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 26);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result expected none actual kind %0d status %0d", $time,
                 result_kind_o, parse_status_o);
      end else begin
        oldest_result = due_results.pop_front();
        check_field("result_kind", oldest_result.kind, result_kind_o);
        check_field("value_byte", oldest_result.value_byte, value_byte_o);
        check_field("value_index", oldest_result.value_index, value_index_o);
        check_field("message_type", oldest_result.msg_type, message_type_o);
        check_field("message_length", oldest_result.msg_len, message_length_o);
        check_field("transaction_high", oldest_result.tx_high, transaction_high_o);
        check_field("transaction_low", oldest_result.tx_low, transaction_low_o);
        check_field("parse_status", oldest_result.status, parse_status_o);
        check_field("last_of_run", oldest_result.last, last_of_run_o);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit eop);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 26) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    packet_byte_i   <= b;
    end_of_packet_i <= eop;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    bytes_sent++;
    parse_byte(b, eop);
  endtask

  task automatic send_frame(input logic [7:0] pkt[$]);
    foreach (pkt[i]) begin
      send_byte(pkt[i], i == pkt.size() - 1);
    end
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (due_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: expected %0d more results actual none", $time, due_results.size());
      due_results.delete();
    end
  endtask

  task automatic write_reg(input smp_pkg::cfg_index_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    case (idx)
      smp_pkg::CFG_MAGIC:     cookie_cfg = data;
      smp_pkg::CFG_USER_TYPE: user_type_cfg = data[15:0];
      smp_pkg::CFG_PASS_TYPE: pass_type_cfg = data[15:0];
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_registers(input logic [31:0] cookie, input logic [15:0] user,
                                 input logic [15:0] pass);
    wait_idle();
    write_reg(smp_pkg::CFG_MAGIC, cookie);
    write_reg(smp_pkg::CFG_USER_TYPE, {16'h0000, user});
    write_reg(smp_pkg::CFG_PASS_TYPE, {16'h0000, pass});
  endtask

  function automatic logic [15:0] pick_attr_type();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return user_type_cfg;
    if (r < 7) return pass_type_cfg;
    return 16'($urandom);
  endfunction

  function automatic packet_end_e pick_end();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return END_CLEAN;
    if (r < 55) return END_TRAILING;
    if (r < 70) return END_OVERRUN;
    if (r < 80) return END_SHORT_HEADER;
    if (r < 90) return END_BAD_MAGIC;
    return END_NOISE;
  endfunction

  task automatic push_attr(ref logic [7:0] pkt[$], input logic [15:0] atype,
                           input logic [15:0] alen, input int nbytes);
    pkt.push_back(atype[15:8]);
    pkt.push_back(atype[7:0]);
    pkt.push_back(alen[15:8]);
    pkt.push_back(alen[7:0]);
    repeat (nbytes) pkt.push_back(8'($urandom));
  endtask

  task automatic send_packet(input packet_end_e how);
    logic [7:0]  pkt[$];
    logic [15:0] mt;
    logic [15:0] ml;
    logic [31:0] mg;
    int          alen;
    int          cut;
    if (how == END_NOISE) begin
      repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
    end else begin
      mt = 16'($urandom);
      ml = 16'($urandom);
      mg = cookie_cfg;
      if (how == END_BAD_MAGIC) begin
        mg = mg ^ (32'h1 << $urandom_range(0, 31));
      end
      pkt = '{mt[15:8], mt[7:0], ml[15:8], ml[7:0], mg[31:24], mg[23:16], mg[15:8], mg[7:0]};
      repeat (smp_pkg::TXID_BYTES) pkt.push_back(8'($urandom));
      case (how)
        END_SHORT_HEADER: begin
          cut = $urandom_range(1, smp_pkg::HDR_BYTES - 1);
          while (pkt.size() > cut) pkt.delete(pkt.size() - 1);
        end
        END_BAD_MAGIC: begin
          cut = $urandom_range(8, 26);
          while (pkt.size() > cut) pkt.delete(pkt.size() - 1);
          while (pkt.size() < cut) pkt.push_back(8'($urandom));
        end
        default: begin
          repeat ($urandom_range(0, 4)) begin
            alen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
            push_attr(pkt, pick_attr_type(), 16'(alen), aligned_len(16'(alen)));
          end
          if (how == END_OVERRUN) begin
            alen = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 65535) : $urandom_range(1, 12);
            cut  = (aligned_len(16'(alen)) > 12) ? 11 : aligned_len(16'(alen)) - 1;
            push_attr(pkt, pick_attr_type(), 16'(alen), $urandom_range(0, cut));
          end else if (how == END_TRAILING) begin
            repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
          end
        end
      endcase
    end
    send_frame(pkt);
  endtask

  task automatic send_mixed(input int n);
    repeat (n) send_packet(pick_end());
  endtask

  task automatic test_short_header();
    send_frame('{8'hFF});
  endtask

  task automatic test_bad_magic();
    send_frame('{8'h00, 8'h00, 8'hFF, 8'hFF,
                 smp_pkg::MAGIC_RESET[31:24], smp_pkg::MAGIC_RESET[23:16],
                 smp_pkg::MAGIC_RESET[15:8], smp_pkg::MAGIC_RESET[7:0] ^ 8'h01});
  endtask

  task automatic test_value_on_last_byte();
    send_frame('{8'h00, 8'h01, 8'h00, 8'h08,
                 smp_pkg::MAGIC_RESET[31:24], smp_pkg::MAGIC_RESET[23:16],
                 smp_pkg::MAGIC_RESET[15:8], smp_pkg::MAGIC_RESET[7:0],
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'hA5, 8'h5A, 8'hFF, 8'h00,
                 smp_pkg::USER_TYPE_RESET[15:8], smp_pkg::USER_TYPE_RESET[7:0],
                 8'h00, 8'h01, 8'h80});
  endtask

  task automatic test_register_extremes();
    logic [15:0] shared_type;
    shared_type = 16'($urandom);
    apply_registers(32'h0000_0000, 16'h0000, 16'hFFFF);
    send_mixed(6);
    apply_registers(32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
    send_mixed(6);
    apply_registers($urandom, shared_type, shared_type);
    send_mixed(8);
    apply_registers(smp_pkg::MAGIC_RESET, smp_pkg::USER_TYPE_RESET,
                    smp_pkg::PASS_TYPE_RESET);
  endtask

  task automatic test_random_packets();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 400) begin
      send_packet(pick_end());
    end
  endtask

  task automatic test_back_to_back();
    int start;
    start = bytes_sent;
    quiet = 1'b1;
    while (bytes_sent - start < 200) begin
      send_packet(pick_end());
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_header();
    test_bad_magic();
    test_value_on_last_byte();
    test_register_extremes();
    test_random_packets();
    test_back_to_back();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
